// ===== design/fyse_pkg.sv =====
package fyse_pkg;

	// deck geometry and random word width
	localparam int DECK_SIZE   = 40;
	localparam int RANDOM_BITS = 31;

	// derived and fixed widths
	localparam int POS_W  = $clog2(DECK_SIZE);
	localparam int SPAN_W = $clog2(DECK_SIZE + 1);
	localparam int BIT_W  = $clog2(RANDOM_BITS);
	localparam int SLOT_W = 6;
	localparam int CARD_W = 6;
	localparam int STEP_W = 4;

	// microprogram step addresses
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_WAIT      = step_t'(0);
	localparam step_t ST_DIV       = step_t'(1);
	localparam step_t ST_CHECK     = step_t'(2);
	localparam step_t ST_RD_POS    = step_t'(3);
	localparam step_t ST_RD_PICK   = step_t'(4);
	localparam step_t ST_WR_PICK   = step_t'(5);
	localparam step_t ST_WR_POS    = step_t'(6);
	localparam step_t ST_EMIT_RD   = step_t'(7);
	localparam step_t ST_EMIT_LD   = step_t'(8);
	localparam step_t ST_EMIT_TEST = step_t'(9);
	localparam step_t ST_EMIT_NEXT = step_t'(10);

	// jump conditions: jump to target when true, else fall through
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_NO_WORD,
		COND_DIV_BUSY,
		COND_REJECT,
		COND_POS_GT1,
		COND_OUT_BUSY,
		COND_K_LAST
	} cond_t;

	// one control word
	typedef struct packed {
		logic  in_ready;
		logic  div_step;
		logic  rd_pos;
		logic  rd_pick;
		logic  wr_pick;
		logic  wr_pos;
		logic  pos_adv;
		logic  k_clr;
		logic  rd_k;
		logic  out_load;
		logic  k_inc;
		cond_t cond;
		step_t target;
	} uctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic no_word;
		logic div_busy;
		logic reject;
		logic pos_gt1;
		logic out_busy;
		logic k_last;
	} flags_t;

endpackage

// ===== design/fyse_ram.sv =====
module fyse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/fyse_seq.sv =====
module fyse_seq import fyse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output uctl_t  uctl
);

	step_t pc_q;
	step_t pc_d;
	logic  take;

	// microprogram
	function automatic uctl_t rom(step_t s);
		uctl_t w;
		w = '0;
		case (s)
			ST_WAIT: begin
				w.in_ready = 1'b1;
				w.cond     = COND_NO_WORD;
				w.target   = ST_WAIT;
			end
			ST_DIV: begin
				w.div_step = 1'b1;
				w.cond     = COND_DIV_BUSY;
				w.target   = ST_DIV;
			end
			ST_CHECK: begin
				w.cond   = COND_REJECT;
				w.target = ST_WAIT;
			end
			ST_RD_POS: begin
				w.rd_pos = 1'b1;
			end
			ST_RD_PICK: begin
				w.rd_pick = 1'b1;
			end
			ST_WR_PICK: begin
				w.wr_pick = 1'b1;
			end
			ST_WR_POS: begin
				w.wr_pos  = 1'b1;
				w.pos_adv = 1'b1;
				w.k_clr   = 1'b1;
				w.cond    = COND_POS_GT1;
				w.target  = ST_WAIT;
			end
			ST_EMIT_RD: begin
				w.rd_k = 1'b1;
			end
			ST_EMIT_LD: begin
				w.out_load = 1'b1;
				w.cond     = COND_OUT_BUSY;
				w.target   = ST_EMIT_LD;
			end
			ST_EMIT_TEST: begin
				w.cond   = COND_K_LAST;
				w.target = ST_WAIT;
			end
			ST_EMIT_NEXT: begin
				w.k_inc  = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = ST_EMIT_RD;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = ST_WAIT;
			end
		endcase
		return w;
	endfunction

	assign uctl = rom(pc_q);

	// condition select
	always_comb begin
		unique case (uctl.cond)
			COND_NEXT:     take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_NO_WORD:  take = flags.no_word;
			COND_DIV_BUSY: take = flags.div_busy;
			COND_REJECT:   take = flags.reject;
			COND_POS_GT1:  take = flags.pos_gt1;
			COND_OUT_BUSY: take = flags.out_busy;
			COND_K_LAST:   take = flags.k_last;
		endcase
	end

	assign pc_d = take ? uctl.target : pc_q + 1'b1;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== design/fisher_yates_shuffle_engine_top.sv =====
// Fisher-Yates shuffle of a DECK_SIZE-entry card store, identity after reset.
// Each random_word transaction is one uniform draw. A small microprogram runs
// it: the word and the random maximum are both reduced modulo span =
// position+1, one bit per cycle; a word at or above the rejection cutoff is
// dropped and the block goes back to wait for the next word. An accepted
// word swaps two entries through the deck RAM (one write port, one
// registered read port) in four more steps. After the swap at position 1
// the whole deck is sent out in slot order, one entry per pass through the
// read, load, test and next steps, holding in the load step while the
// result side stalls, with last_of_run on the final slot; the next word can
// be taken while that final entry still waits in the output register.
// The next shuffle starts from the order just emitted.
module fisher_yates_shuffle_engine_top import fyse_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   word_valid,
	output logic                   word_stall,
	input  logic [RANDOM_BITS-1:0] random_word,
	output logic                   deck_valid,
	input  logic                   deck_stall,
	output logic [SLOT_W-1:0]      slot,
	output logic [CARD_W-1:0]      card_index,
	output logic                   last_of_run
);

	localparam logic [RANDOM_BITS-1:0] RMAX = '1;

	uctl_t  uctl;
	flags_t flags;

	logic                   word_fire;
	logic [RANDOM_BITS-1:0] word_q;
	logic [BIT_W-1:0]       bit_q;
	logic [SPAN_W-1:0]      rw_q;
	logic [SPAN_W-1:0]      rm_q;
	logic [SPAN_W-1:0]      span;
	logic [RANDOM_BITS-1:0] cutoff;
	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       k_q;
	logic [POS_W-1:0]       pick;
	logic [POS_W-1:0]       a_q;
	logic [POS_W-1:0]       b_q;

	logic                   ram_we;
	logic [POS_W-1:0]       ram_waddr;
	logic [POS_W-1:0]       ram_wdata;
	logic                   ram_re;
	logic [POS_W-1:0]       ram_raddr;
	logic [POS_W-1:0]       ram_rdata;
	logic [DECK_SIZE-1:0]   vld_q;
	logic                   rd_vld_q;
	logic [POS_W-1:0]       rd_addr_q;
	logic [POS_W-1:0]       rd_value;

	logic                   out_busy;
	logic                   out_load;
	logic                   deck_valid_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CARD_W-1:0]      card_q;
	logic                   last_q;

	// one restoring step of remainder by span
	function automatic logic [SPAN_W-1:0] rem_step(
		logic [SPAN_W-1:0] r,
		logic              b,
		logic [SPAN_W-1:0] d
	);
		logic [SPAN_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[SPAN_W-1:0];
	endfunction

	fyse_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uctl   (uctl)
	);

	// input handshake
	assign word_fire  = word_valid & uctl.in_ready;
	assign word_stall = ~uctl.in_ready;

	assign span   = SPAN_W'(pos_q) + 1'b1;
	assign cutoff = RMAX - RANDOM_BITS'(rm_q);
	assign pick   = rw_q[POS_W-1:0];

	// captured word
	always_ff @(posedge clk) begin
		if (word_fire) begin
			word_q <= random_word;
		end
	end

	// bit-serial remainder of word and of RMAX
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			rw_q  <= '0;
			rm_q  <= '0;
		end else if (word_fire) begin
			bit_q <= BIT_W'(RANDOM_BITS - 1);
			rw_q  <= '0;
			rm_q  <= '0;
		end else if (uctl.div_step) begin
			bit_q <= bit_q - 1'b1;
			rw_q  <= rem_step(rw_q, word_q[bit_q], span);
			rm_q  <= rem_step(rm_q, 1'b1, span);
		end
	end

	// position and emit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_W'(DECK_SIZE - 1);
			k_q   <= '0;
		end else begin
			if (uctl.pos_adv) begin
				pos_q <= flags.pos_gt1 ? pos_q - 1'b1 : POS_W'(DECK_SIZE - 1);
			end
			if (uctl.k_clr) begin
				k_q <= '0;
			end else if (uctl.k_inc) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// deck RAM port steering
	assign ram_re    = uctl.rd_pos | uctl.rd_pick | uctl.rd_k;
	assign ram_raddr = uctl.rd_pos ? pos_q : (uctl.rd_pick ? pick : k_q);
	assign ram_we    = uctl.wr_pick | uctl.wr_pos;
	assign ram_waddr = uctl.wr_pick ? pick : pos_q;
	assign ram_wdata = uctl.wr_pick ? a_q : b_q;

	fyse_ram #(
		.WIDTH (POS_W),
		.DEPTH (DECK_SIZE)
	) u_deck (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// written-entry flags; unwritten entries read as their own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_vld_q  <= vld_q[ram_raddr];
			rd_addr_q <= ram_raddr;
		end
	end

	assign rd_value = rd_vld_q ? ram_rdata : rd_addr_q;

	// swap operands
	always_ff @(posedge clk) begin
		if (uctl.rd_pick) begin
			a_q <= rd_value;
		end
		if (uctl.wr_pick) begin
			b_q <= rd_value;
		end
	end

	// output register
	assign out_busy = deck_valid_q & deck_stall;
	assign out_load = uctl.out_load & ~out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deck_valid_q <= 1'b0;
		end else if (out_load) begin
			deck_valid_q <= 1'b1;
		end else if (!deck_stall) begin
			deck_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			slot_q <= SLOT_W'(k_q);
			card_q <= CARD_W'(rd_value);
			last_q <= flags.k_last;
		end
	end

	assign deck_valid  = deck_valid_q;
	assign slot        = slot_q;
	assign card_index  = card_q;
	assign last_of_run = last_q;

	// status to the sequencer
	assign flags.no_word  = ~word_valid;
	assign flags.div_busy = (bit_q != '0);
	assign flags.reject   = ~(word_q < cutoff);
	assign flags.pos_gt1  = (pos_q != POS_W'(1));
	assign flags.out_busy = out_busy;
	assign flags.k_last   = (k_q == POS_W'(DECK_SIZE - 1));

endmodule

// ===== design/fyse_chk.sv =====
module fyse_chk import fyse_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   word_valid,
	input logic                   word_stall,
	input logic [RANDOM_BITS-1:0] random_word,
	input logic                   deck_valid,
	input logic                   deck_stall,
	input logic [SLOT_W-1:0]      slot,
	input logic [CARD_W-1:0]      card_index,
	input logic                   last_of_run
);

	// a stalled word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_stall |=> word_valid && $stable(random_word))
		else $error("stalled word changed");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		deck_valid && deck_stall |=> deck_valid && $stable(slot) && $stable(card_index)
			&& $stable(last_of_run))
		else $error("stalled result changed");

	// last marker sits exactly on the final slot
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		deck_valid |-> (last_of_run == (slot == SLOT_W'(DECK_SIZE - 1))))
		else $error("last marker on wrong slot");

	// no word is taken while the deck is still being sent out
	a_emit_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		deck_valid && !last_of_run |-> word_stall)
		else $error("word accepted during deck emission");

	// a taken word keeps the divider busy on the next cycle
	a_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_stall |=> word_stall)
		else $error("word accepted back to back");

endmodule

bind fisher_yates_shuffle_engine_top fyse_chk u_chk (.*);
